>>> rtl/wavhp_pkg.sv
package wavhp_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_RIFF = 3'd1,
        ST_BAD_WAVE = 3'd2,
        ST_BAD_FMT  = 3'd3,
        ST_BAD_DATA = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] samples_per_second;
        logic [31:0] data_bytes;
        logic [5:0]  header_bytes;
    } t_result;

    // little-endian tags as they sit in the four-byte window
    localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE       = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT        = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA       = 32'h6174_6164;
    localparam logic [15:0] NO_CBSIZE_MARK = 16'h6164;

    // offset of the last byte of each field
    localparam logic [5:0] POS_RIFF       = 6'd3;
    localparam logic [5:0] POS_WAVE       = 6'd11;
    localparam logic [5:0] POS_FMT        = 6'd15;
    localparam logic [5:0] POS_CHANNELS   = 6'd23;
    localparam logic [5:0] POS_RATE       = 6'd27;
    localparam logic [5:0] POS_BITS       = 6'd35;
    localparam logic [5:0] POS_CBSIZE     = 6'd37;
    localparam logic [5:0] POS_DATA_SHORT = 6'd39;
    localparam logic [5:0] POS_DATA_LONG  = 6'd41;
    localparam logic [5:0] POS_SIZE_SHORT = 6'd43;
    localparam logic [5:0] POS_SIZE_LONG  = 6'd45;

    localparam logic [5:0] HDR_SHORT = 6'd44;
    localparam logic [5:0] HDR_LONG  = 6'd46;

endpackage

>>> rtl/wav_header_parser_unit.sv
// A result is registered (output register, or skid if the output stalls) when its last byte is taken.
// Throughput: one header byte per cycle; the input stalls only while a second
//   result waits in the skid register behind a stalled output.
// Reset (synchronous, active low): byte position, done flag and output valids clear;
//   the next byte is taken as offset 0. Payload registers are not reset.
module wav_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_channel_count,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_samples_per_second,
    output logic [31:0] o_data_bytes,
    output logic [5:0]  o_header_bytes
);

    logic [5:0]  r_pos,      n_pos;
    logic [31:0] r_window,   n_window;
    logic [15:0] r_channels, n_channels;
    logic [15:0] r_bits,     n_bits;
    logic [31:0] r_rate,     n_rate;
    logic        r_short,    n_short;
    logic        r_done,     n_done;

    wavhp_pkg::t_result r_out, r_skid, n_res;
    logic               r_out_valid, r_skid_valid;
    logic               n_res_valid;

    logic       in_acc;
    logic       out_free;
    logic [5:0] pos_cur;
    logic       done_cur;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_skid_valid;

    // a start flag restarts the parse on this very byte
    assign pos_cur  = i_first_byte ? 6'd0 : r_pos;
    assign done_cur = i_first_byte ? 1'b0 : r_done;

    always_comb begin
        n_pos       = r_pos;
        n_window    = r_window;
        n_channels  = r_channels;
        n_bits      = r_bits;
        n_rate      = r_rate;
        n_short     = r_short;
        n_done      = done_cur;
        n_res_valid = 1'b0;
        n_res       = '0;
        n_res.status = wavhp_pkg::ST_OK;

        if (!done_cur) begin
            n_window = {i_data_byte, r_window[31:8]};
            n_pos    = pos_cur + 6'd1;
            unique case (pos_cur)
                wavhp_pkg::POS_RIFF: begin
                    if (n_window != wavhp_pkg::TAG_RIFF) begin
                        n_res_valid  = 1'b1;
                        n_res.status = wavhp_pkg::ST_BAD_RIFF;
                    end
                end
                wavhp_pkg::POS_WAVE: begin
                    if (n_window != wavhp_pkg::TAG_WAVE) begin
                        n_res_valid  = 1'b1;
                        n_res.status = wavhp_pkg::ST_BAD_WAVE;
                    end
                end
                wavhp_pkg::POS_FMT: begin
                    if (n_window != wavhp_pkg::TAG_FMT) begin
                        n_res_valid  = 1'b1;
                        n_res.status = wavhp_pkg::ST_BAD_FMT;
                    end
                end
                wavhp_pkg::POS_CHANNELS: n_channels = n_window[31:16];
                wavhp_pkg::POS_RATE:     n_rate     = n_window;
                wavhp_pkg::POS_BITS:     n_bits     = n_window[31:16];
                wavhp_pkg::POS_CBSIZE: begin
                    n_short = (n_window[31:16] == wavhp_pkg::NO_CBSIZE_MARK);
                end
                wavhp_pkg::POS_DATA_SHORT: begin
                    if (r_short && n_window != wavhp_pkg::TAG_DATA) begin
                        n_res_valid  = 1'b1;
                        n_res.status = wavhp_pkg::ST_BAD_DATA;
                    end
                end
                wavhp_pkg::POS_DATA_LONG: begin
                    if (!r_short && n_window != wavhp_pkg::TAG_DATA) begin
                        n_res_valid  = 1'b1;
                        n_res.status = wavhp_pkg::ST_BAD_DATA;
                    end
                end
                wavhp_pkg::POS_SIZE_SHORT, wavhp_pkg::POS_SIZE_LONG: begin
                    if (r_short == (pos_cur == wavhp_pkg::POS_SIZE_SHORT)) begin
                        n_res_valid              = 1'b1;
                        n_res.channel_count      = r_channels;
                        n_res.sample_bits        = r_bits;
                        n_res.samples_per_second = r_rate;
                        n_res.data_bytes         = n_window;
                        n_res.header_bytes       = r_short ? wavhp_pkg::HDR_SHORT
                                                           : wavhp_pkg::HDR_LONG;
                    end
                end
                default: ;
            endcase
            if (n_res_valid) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_done <= 1'b0;
        end else if (in_acc) begin
            r_pos  <= n_pos;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_window   <= n_window;
            r_channels <= n_channels;
            r_bits     <= n_bits;
            r_rate     <= n_rate;
            r_short    <= n_short;
        end
    end

    // output register with a one-entry skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc && n_res_valid;
            end
        end else if (in_acc && n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (in_acc && n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out.status;
    assign o_channel_count      = r_out.channel_count;
    assign o_sample_bits        = r_out.sample_bits;
    assign o_samples_per_second = r_out.samples_per_second;
    assign o_data_bytes         = r_out.data_bytes;
    assign o_header_bytes       = r_out.header_bytes;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_ok_header_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == wavhp_pkg::ST_OK) |->
        (r_out.header_bytes == wavhp_pkg::HDR_SHORT ||
         r_out.header_bytes == wavhp_pkg::HDR_LONG))
        else $error("ok result with bad header length");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != wavhp_pkg::ST_OK) |->
        (r_out.header_bytes == 6'd0 && r_out.data_bytes == 32'd0 &&
         r_out.channel_count == 16'd0))
        else $error("error result carries nonzero fields");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_done && !i_first_byte) |=> (r_skid_valid == $past(r_skid_valid) ||
         !r_skid_valid))
        else $error("result produced after parse finished");
`endif

endmodule
